// File: design/plc_pkg.sv
`default_nettype none

package plc_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  // count runs 0..DEPTH, cell index 0..DEPTH-1
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // common width for comparing a position against the count
  localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_FIND   = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_LEFT  = 2'd1,
    CELL_TAKE_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     live;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/plc_cell.sv
`default_nettype none

module plc_cell (
  input  wire logic               clk,
  input  wire plc_pkg::cell_ctl_t ctl,
  input  wire plc_pkg::word_t     left_word,
  input  wire plc_pkg::word_t     right_word,
  input  wire plc_pkg::word_t     new_word,
  input  wire plc_pkg::word_t     key,
  output plc_pkg::word_t          word,
  output logic                    hit
);

  plc_pkg::word_t word_r;
  plc_pkg::word_t word_nxt;

  always_comb begin
    case (ctl.op)
      plc_pkg::CELL_HOLD:       word_nxt = word_r;
      plc_pkg::CELL_TAKE_LEFT:  word_nxt = left_word;
      plc_pkg::CELL_TAKE_RIGHT: word_nxt = right_word;
      plc_pkg::CELL_LOAD:       word_nxt = new_word;
      default:                  word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  // only occupied cells take part in a search
  assign hit  = ctl.live && (word_r == key);

endmodule

`default_nettype wire

// File: design/positional_list_engine.sv
// positional_list_engine: ordered list of up to 16 signed words, positions from 1
//
// in channel (in_valid/in_ready): in_command, in_position, in_value
//   read, find, insert, delete or clear
// out channel (out_valid/out_ready): out_status, out_read_value,
//   out_found_position, out_entry_count; one result item per command
//
// the list sits in a row of cells, one word each; insert and delete move
// every cell at or beyond the position one step along the row in the
// same cycle, find compares all occupied cells at once
// out_valid rises in the cycle after acceptance; one item per cycle is
// sustained while the receiver takes results, the single output register
// being the only stage between the two sides
// when out_ready is low the result is held and in_ready drops until it is
// taken, so nothing else is accepted meanwhile
// reset empties the list (count to zero) and drops out_valid; the cell
// words are not cleared, entries beyond the count are never read
`default_nettype none

module positional_list_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [4:0]  in_position,
  input  wire logic signed [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic signed [31:0] out_read_value,
  output logic [4:0]       out_found_position,
  output logic [4:0]       out_entry_count
);

  localparam int DEPTH = plc_pkg::DEPTH;
  localparam int CNT_W = plc_pkg::CNT_W;
  localparam int IDX_W = plc_pkg::IDX_W;
  localparam int CMP_W = plc_pkg::CMP_W;

  logic                    accept;
  plc_pkg::cmd_e           cmd;
  plc_pkg::word_t          key;
  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic [IDX_W-1:0]        rd_idx;
  logic                    rd_ok;
  logic                    ins_ok;
  logic                    del_ok;
  logic                    full;

  plc_pkg::cell_ctl_t      cell_ctl  [DEPTH];
  plc_pkg::word_t          cell_word [DEPTH];
  logic [DEPTH-1:0]        cell_hit;
  logic                    any_hit;
  logic [4:0]              hit_pos;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  plc_pkg::status_e        status_r;
  plc_pkg::status_e        status_nxt;
  logic signed [31:0]      rd_r;
  logic signed [31:0]      rd_nxt;
  logic [4:0]              found_r;
  logic [4:0]              found_nxt;
  logic [4:0]              cnt_out_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign cmd      = plc_pkg::cmd_e'(in_command);
  assign key      = plc_pkg::word_t'(in_value);

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign rd_idx  = IDX_W'(in_position - 5'd1);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign rd_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1)) && !full;
  assign del_ok  = rd_ok;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(gi);
    plc_pkg::word_t left_w;
    plc_pkg::word_t right_w;

    if (gi == 0) begin : g_first
      assign left_w = key;
    end else begin : g_mid_l
      assign left_w = cell_word[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign right_w = cell_word[gi];
    end else begin : g_mid_r
      assign right_w = cell_word[gi+1];
    end

    always_comb begin
      cell_ctl[gi].live = (IDX < cnt_ext);
      cell_ctl[gi].op   = plc_pkg::CELL_HOLD;
      if (accept) begin
        case (cmd)
          plc_pkg::CMD_INSERT: begin
            if (ins_ok) begin
              if (IDX >= pos_ext) begin
                cell_ctl[gi].op = plc_pkg::CELL_TAKE_LEFT;
              end else if (IDX + CMP_W'(1) == pos_ext) begin
                cell_ctl[gi].op = plc_pkg::CELL_LOAD;
              end
            end
          end
          plc_pkg::CMD_DELETE: begin
            // cells from the removed one upwards take their right neighbour
            if (del_ok && (IDX + CMP_W'(1) >= pos_ext)) begin
              cell_ctl[gi].op = plc_pkg::CELL_TAKE_RIGHT;
            end
          end
          default: cell_ctl[gi].op = plc_pkg::CELL_HOLD;
        endcase
      end
    end

    plc_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[gi]),
      .left_word  (left_w),
      .right_word (right_w),
      .new_word   (key),
      .key        (key),
      .word       (cell_word[gi]),
      .hit        (cell_hit[gi])
    );
  end

  // lowest matching position wins
  always_comb begin
    hit_pos = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (cell_hit[k]) begin
        hit_pos = 5'(k + 1);
      end
    end
  end
  assign any_hit = |cell_hit;

  always_comb begin
    status_nxt = plc_pkg::ST_OK;
    rd_nxt     = '0;
    found_nxt  = '0;
    count_nxt  = count_r;
    case (cmd)
      plc_pkg::CMD_READ: begin
        if (rd_ok) begin
          rd_nxt = 32'(cell_word[rd_idx]);
        end else begin
          status_nxt = plc_pkg::ST_BAD_POS;
        end
      end
      plc_pkg::CMD_FIND: begin
        if (any_hit) begin
          found_nxt = hit_pos;
        end else begin
          status_nxt = plc_pkg::ST_MISSING;
        end
      end
      plc_pkg::CMD_INSERT: begin
        if ((pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1))) begin
          status_nxt = plc_pkg::ST_BAD_POS;
        end else if (full) begin
          status_nxt = plc_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      plc_pkg::CMD_DELETE: begin
        if (del_ok) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = plc_pkg::ST_BAD_POS;
        end
      end
      plc_pkg::CMD_CLEAR: count_nxt = '0;
      default: status_nxt = plc_pkg::ST_OK;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      rd_r      <= rd_nxt;
      found_r   <= found_nxt;
      cnt_out_r <= 5'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_read_value     = rd_r;
  assign out_found_position = found_r;
  assign out_entry_count    = cnt_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == plc_pkg::CMD_INSERT) && (status_nxt == plc_pkg::ST_OK)
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("successful insert did not grow the list");

  a_miss_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == plc_pkg::ST_MISSING) |-> found_r == '0)
    else $error("search miss reports a position");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> cnt_out_r == 5'(count_r))
    else $error("reported count differs from list count");

endmodule

`default_nettype wire

// File: sim/tb_positional_list_engine.sv
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // command codes the block leaves unused
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam plc_pkg::word_t W_MIN     = 32'h8000_0000;
  localparam plc_pkg::word_t W_MAX     = 32'h7fff_ffff;
  localparam plc_pkg::word_t W_ONES    = 32'hffff_ffff;
  localparam plc_pkg::word_t FILL_BASE = 32'h0001_0000;

  localparam int RANDOM_ITEMS = 1400;
  localparam int STEADY_ITEMS = 150;
  localparam int HOLD_AT      = 400;
  localparam int DRAIN_AT     = 800;
  localparam int HOLD_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    plc_pkg::status_e status;
    plc_pkg::word_t   rd;
    logic [4:0]       found;
    logic [4:0]       cnt;
  } list_result_t;

  typedef struct {
    logic [2:0]     cmd;
    logic [4:0]     pos;
    plc_pkg::word_t val;
    int             reps;
    bit             typed;
    list_result_t   res;
  } plan_row_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [2:0]     in_command = '0;
  logic [4:0]     in_position = '0;
  plc_pkg::word_t in_value = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [1:0]     out_status;
  plc_pkg::word_t out_read_value;
  logic [4:0]     out_found_position;
  logic [4:0]     out_entry_count;

  // shadow copy of the list
  plc_pkg::word_t shadow_words [plc_pkg::DEPTH];
  int             shadow_count = 0;

  list_result_t pending_results [$];
  list_result_t want;
  plan_row_t    plan [$];

  int mismatches = 0;
  int results_seen = 0;
  int commands_sent = 0;
  int rejected_full = 0;
  bit steady = 1'b0;
  bit stall_request = 1'b0;

  positional_list_engine dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_position, .in_value,
    .out_valid, .out_ready, .out_status, .out_read_value,
    .out_found_position, .out_entry_count
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic list_result_t list_apply(logic [2:0] cmd, logic [4:0] pos,
                                              plc_pkg::word_t val);
    list_result_t r;
    int p;
    int k;
    p = pos;
    r.status = plc_pkg::ST_OK;
    r.rd = '0;
    r.found = '0;
    case (cmd)
      plc_pkg::CMD_READ: begin
        if (p >= 1 && p <= shadow_count) r.rd = shadow_words[p-1];
        else r.status = plc_pkg::ST_BAD_POS;
      end
      plc_pkg::CMD_FIND: begin
        r.status = plc_pkg::ST_MISSING;
        for (k = 0; k < shadow_count; k++) begin
          if (r.status == plc_pkg::ST_MISSING && shadow_words[k] == val) begin
            r.status = plc_pkg::ST_OK;
            r.found = 5'(k + 1);
          end
        end
      end
      plc_pkg::CMD_INSERT: begin
        // position is checked ahead of fullness
        if (p < 1 || p > shadow_count + 1) begin
          r.status = plc_pkg::ST_BAD_POS;
        end else if (shadow_count >= plc_pkg::DEPTH) begin
          r.status = plc_pkg::ST_FULL;
        end else begin
          for (k = shadow_count; k >= p; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[p-1] = val;
          shadow_count++;
        end
      end
      plc_pkg::CMD_DELETE: begin
        if (p < 1 || p > shadow_count) begin
          r.status = plc_pkg::ST_BAD_POS;
        end else begin
          for (k = p - 1; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k+1];
          shadow_count--;
        end
      end
      plc_pkg::CMD_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.cnt = 5'(shadow_count);
    return r;
  endfunction

  task automatic add_row(logic [2:0] cmd, logic [4:0] pos, plc_pkg::word_t val, int reps);
    plan_row_t row;
    row.cmd = cmd;
    row.pos = pos;
    row.val = val;
    row.reps = reps;
    row.typed = 1'b0;
    row.res = '0;
    plan.push_back(row);
  endtask

  task automatic add_checked(logic [2:0] cmd, logic [4:0] pos, plc_pkg::word_t val,
                             plc_pkg::status_e st, plc_pkg::word_t rd,
                             logic [4:0] found, logic [4:0] cnt);
    plan_row_t row;
    row.cmd = cmd;
    row.pos = pos;
    row.val = val;
    row.reps = 1;
    row.typed = 1'b1;
    row.res.status = st;
    row.res.rd = rd;
    row.res.found = found;
    row.res.cnt = cnt;
    plan.push_back(row);
  endtask

  task automatic send(logic [2:0] cmd, logic [4:0] pos, plc_pkg::word_t val, bit typed,
                      list_result_t fixed);
    list_result_t got;
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    got = list_apply(cmd, pos, val);
    if (typed) pending_results.push_back(fixed);
    else pending_results.push_back(got);
    commands_sent++;
    if (got.status == plc_pkg::ST_FULL) rejected_full++;
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pick_command(output logic [2:0] cmd, output logic [4:0] pos,
                              output plc_pkg::word_t val);
    int sel;
    int ins_w;
    int top;
    sel = $urandom_range(0, 99);
    // back off inserts when the list is close to full so it keeps moving
    ins_w = (shadow_count >= plc_pkg::DEPTH - 2) ? 20 : 40;
    if (sel < 3) cmd = plc_pkg::CMD_CLEAR;
    else if (sel < 5) cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    else if (sel < 5 + ins_w) cmd = plc_pkg::CMD_INSERT;
    else if (sel < 70) cmd = plc_pkg::CMD_DELETE;
    else if (sel < 85) cmd = plc_pkg::CMD_READ;
    else cmd = plc_pkg::CMD_FIND;

    top = (cmd == plc_pkg::CMD_INSERT) ? shadow_count + 1 : shadow_count;
    if (top < 1) top = 1;
    if ($urandom_range(0, 4) == 0) pos = 5'($urandom_range(0, 31));
    else pos = 5'($urandom_range(1, top));

    case ($urandom_range(0, 3))
      0: val = $urandom;
      1: val = plc_pkg::word_t'(int'($urandom_range(0, 7)) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0: val = W_MIN;
          1: val = W_MAX;
          2: val = '0;
          default: val = W_ONES;
        endcase
      end
      default: val = (shadow_count > 0) ? shadow_words[$urandom_range(0, shadow_count - 1)]
                                        : plc_pkg::word_t'($urandom);
    endcase
    // searches mostly aim at something that is there
    if (cmd == plc_pkg::CMD_FIND && shadow_count > 0 && $urandom_range(0, 1) == 0)
      val = shadow_words[$urandom_range(0, shadow_count - 1)];
  endtask

  // receiver: short random stalls, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_request = 1'b0;
        out_ready <= 1'b1;
      end else if (!steady && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("result item with nothing expected: status %0d count %0d",
                   out_status, out_entry_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_status !== want.status || out_read_value !== want.rd ||
            out_found_position !== want.found || out_entry_count !== want.cnt) begin
          if (mismatches < 10)
            $display({"mismatch on result %0d: want st %0d rd %h pos %0d cnt %0d,",
                      " got st %0d rd %h pos %0d cnt %0d"},
                     results_seen, want.status, want.rd, want.found, want.cnt,
                     out_status, out_read_value, out_found_position, out_entry_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_positional_list_engine NOT OK");
    $finish;
  end

  initial begin
    int i;
    int r;
    int n;
    logic [2:0] cmd;
    logic [4:0] pos;
    plc_pkg::word_t val;

    // empty list after reset
    add_checked(plc_pkg::CMD_READ,   5'd1,  '0,     plc_pkg::ST_BAD_POS, '0, 5'd0, 5'd0);
    add_checked(plc_pkg::CMD_FIND,   5'd0,  '0,     plc_pkg::ST_MISSING, '0, 5'd0, 5'd0);
    add_checked(plc_pkg::CMD_DELETE, 5'd1,  '0,     plc_pkg::ST_BAD_POS, '0, 5'd0, 5'd0);
    add_checked(plc_pkg::CMD_INSERT, 5'd0,  W_ONES, plc_pkg::ST_BAD_POS, '0, 5'd0, 5'd0);
    add_checked(plc_pkg::CMD_INSERT, 5'd2,  W_ONES, plc_pkg::ST_BAD_POS, '0, 5'd0, 5'd0);
    // word extremes
    add_checked(plc_pkg::CMD_INSERT, 5'd1,  W_MAX,  plc_pkg::ST_OK,      '0, 5'd0, 5'd1);
    add_checked(plc_pkg::CMD_INSERT, 5'd2,  W_MIN,  plc_pkg::ST_OK,      '0, 5'd0, 5'd2);
    add_checked(plc_pkg::CMD_READ,   5'd1,  '0,     plc_pkg::ST_OK,      W_MAX, 5'd0, 5'd2);
    add_checked(plc_pkg::CMD_READ,   5'd2,  '0,     plc_pkg::ST_OK,      W_MIN, 5'd0, 5'd2);
    add_checked(plc_pkg::CMD_READ,   5'd3,  '0,     plc_pkg::ST_BAD_POS, '0, 5'd0, 5'd2);
    add_checked(plc_pkg::CMD_FIND,   5'd0,  W_MIN,  plc_pkg::ST_OK,      '0, 5'd2, 5'd2);
    add_checked(plc_pkg::CMD_FIND,   5'd31, W_MAX,  plc_pkg::ST_OK,      '0, 5'd1, 5'd2);
    add_row(plc_pkg::CMD_INSERT, 5'd2, W_ONES, 1);
    add_row(plc_pkg::CMD_DELETE, 5'd1, '0, 1);
    // unused codes leave everything alone
    add_checked(CMD_SPARE_LO, 5'd3,  W_ONES, plc_pkg::ST_OK, '0, 5'd0, 5'd2);
    add_checked(CMD_SPARE_HI, 5'd31, W_MIN,  plc_pkg::ST_OK, '0, 5'd0, 5'd2);
    add_checked(plc_pkg::CMD_READ,   5'd31, '0,     plc_pkg::ST_BAD_POS, '0, 5'd0, 5'd2);
    add_checked(plc_pkg::CMD_DELETE, 5'd0,  '0,     plc_pkg::ST_BAD_POS, '0, 5'd0, 5'd2);
    add_checked(plc_pkg::CMD_CLEAR,  5'd9,  W_ONES, plc_pkg::ST_OK,      '0, 5'd0, 5'd0);
    // fill to the top, each new item at the head
    add_row(plc_pkg::CMD_INSERT, 5'd1, FILL_BASE, plc_pkg::DEPTH);
    add_checked(plc_pkg::CMD_INSERT, 5'd17, W_ONES, plc_pkg::ST_FULL,    '0, 5'd0, 5'd16);
    add_checked(plc_pkg::CMD_INSERT, 5'd1,  W_ONES, plc_pkg::ST_FULL,    '0, 5'd0, 5'd16);
    add_checked(plc_pkg::CMD_INSERT, 5'd18, W_ONES, plc_pkg::ST_BAD_POS, '0, 5'd0, 5'd16);
    add_row(plc_pkg::CMD_READ,   5'd16, '0, 1);
    add_row(plc_pkg::CMD_FIND,   5'd0,  FILL_BASE, 1);
    add_row(plc_pkg::CMD_DELETE, 5'd16, '0, 1);
    add_row(plc_pkg::CMD_DELETE, 5'd1,  '0, 1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < plan.size(); i++) begin
      for (r = 0; r < plan[i].reps; r++)
        send(plan[i].cmd, plan[i].pos, plan[i].val + plc_pkg::word_t'(r), plan[i].typed,
             plan[i].res);
    end
    drain_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) stall_request = 1'b1;
      if (n == DRAIN_AT) drain_results();
      steady = (n >= RANDOM_ITEMS - STEADY_ITEMS);
      pick_command(cmd, pos, val);
      send(cmd, pos, val, 1'b0, '0);
    end
    drain_results();
    repeat (8) @(posedge clk);

    $display("%0d commands driven, %0d results compared, %0d inserts refused on a full list",
             commands_sent, results_seen, rejected_full);
    $display("%0d mismatches, %0d results still owed", mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_positional_list_engine OK");
    else
      $display("tb_positional_list_engine NOT OK");
    $finish;
  end

endmodule
